// ----- design/snu_pkg.sv -----
// Package for the spiking neuron update block: types, constants and helpers.
`timescale 1ns / 1ps

package snu_pkg;

  // Neuron index width and the depth of the per-neuron state memory.
  localparam int NEURON_W = 10;
  localparam int NEURONS  = 1 << NEURON_W;

  // Configuration register index width.
  localparam int CFG_IDX_W = 4;

  // Item operation codes.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_EXC   = 4'd0,
    REG_THRESHOLD = 4'd1,
    REG_RESET_C   = 4'd2,
    REG_RECOV_B   = 4'd3,
    REG_A_EXC     = 4'd4,
    REG_A_INH     = 4'd5,
    REG_D_EXC     = 4'd6,
    REG_D_INH     = 4'd7
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [10:0]        NUM_EXC_RST   = 11'd800;
  localparam logic signed [31:0] THRESHOLD_RST = 32'sd1966080;
  localparam logic signed [31:0] RESET_C_RST   = -32'sd4259840;
  localparam logic [16:0]        RECOV_B_RST   = 17'd13107;
  localparam logic [16:0]        A_EXC_RST     = 17'd1311;
  localparam logic [16:0]        A_INH_RST     = 17'd6554;
  localparam logic signed [31:0] D_EXC_RST     = 32'sd524288;
  localparam logic signed [31:0] D_INH_RST     = 32'sd131072;

  // Quadratic term: 0.04*v*v is v*v / (65536 * 25), rounded half up.
  localparam logic [55:0]        QUAD_BIAS = 56'd819200;
  // Above this magnitude of v the half-step saturates high anyway.
  localparam logic signed [31:0] BIG_LIM   = 32'sd268435456;
  // Quadratic term used once |v| is past BIG_LIM; large enough to force saturation.
  localparam logic [35:0]        QUAD_CAP  = 36'h8_0000_0000;
  // Divide by 25 for values below 2^25: (x * DIV25_MUL) >> DIV25_SHIFT.
  localparam logic [25:0]        DIV25_MUL = 26'd42949673;
  localparam int                 DIV25_SHIFT = 30;
  // 140 in Q16.16.
  localparam logic signed [36:0] LIN_BIAS  = 37'sd9175040;
  // Half of one Q16.16 step, for rounding Q32.32 products half up.
  localparam int                 RND_HALF  = 32768;

  // Configuration register set.
  typedef struct packed {
    logic [10:0]        num_exc;
    logic signed [31:0] threshold_v;
    logic signed [31:0] reset_c;
    logic [16:0]        recovery_b;
    logic [16:0]        a_exc;
    logic [16:0]        a_inh;
    logic signed [31:0] d_exc;
    logic signed [31:0] d_inh;
  } cfg_t;

  // One item as it travels down the update pipeline.
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [NEURON_W-1:0] neuron;
    logic               exc;
    logic               spiked;
    logic signed [31:0] cur;
    logic signed [31:0] v;
    logic signed [31:0] u;
  } item_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// ----- design/snu_in_if.sv -----
// Input channel: tick and load items for the neuron update block.
`timescale 1ns / 1ps

interface snu_in_if import snu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [NEURON_W-1:0] neuron;
  logic signed [31:0]  current;
  logic signed [31:0]  init_v;
  logic signed [31:0]  init_u;

  modport source (output valid, output op, output neuron, output current,
                  output init_v, output init_u, input ready);
  modport sink   (input valid, input op, input neuron, input current,
                  input init_v, input init_u, output ready);
endinterface

// ----- design/snu_out_if.sv -----
// Result channel: updated neuron state, one item per accepted input item.
`timescale 1ns / 1ps

interface snu_out_if import snu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NEURON_W-1:0] neuron_out;
  logic                spiked;
  logic signed [31:0]  v_out;
  logic signed [31:0]  u_out;

  modport source (output valid, output neuron_out, output spiked, output v_out,
                  output u_out, input ready);
  modport sink   (input valid, input neuron_out, input spiked, input v_out,
                  input u_out, output ready);
endinterface

// ----- design/snu_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface snu_cfg_if import snu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/snu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module snu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/snu_half.sv -----
// One pipelined half-step of the membrane integration, five register stages.
`timescale 1ns / 1ps

module snu_half import snu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  item_t               item_in,
  output item_t               item_out,
  input  logic [NEURON_W-1:0] probe_neuron,
  output logic                probe_hit
);

  // Stage A: square of |v| and the linear part 7v + 140 - u + I.
  logic               big_a;
  logic [27:0]        vabs_a;
  logic [55:0]        sq_a;
  logic signed [36:0] lin_a;

  item_t              it_a_r;
  logic               big_a_r;
  logic [55:0]        sq_a_r;
  logic signed [36:0] lin_a_r;

  always_comb begin
    big_a  = (item_in.v >= BIG_LIM) || (item_in.v <= -BIG_LIM);
    vabs_a = item_in.v[31] ? 28'(-item_in.v) : item_in.v[27:0];
    sq_a   = 56'(vabs_a) * 56'(vabs_a);
    // Folding 2v in here lets the last stage take floor(t/2) directly.
    lin_a  = (37'(item_in.v) <<< 3) - 37'(item_in.v) + LIN_BIAS
             - 37'(item_in.u) + 37'(item_in.cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_a_r.valid <= 1'b0;
    end else if (en) begin
      it_a_r <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_a_r <= big_a;
      sq_a_r  <= sq_a;
      lin_a_r <= lin_a;
    end
  end

  // Stage B: round away the low 16 bits, first quotient digit of the divide by 25.
  logic [39:0] y_b;
  logic [45:0] prod1_b;

  item_t              it_b_r;
  logic               big_b_r;
  logic signed [36:0] lin_b_r;
  logic [15:0]        q1_b_r;
  logic [19:0]        yh_b_r;
  logic [19:0]        yl_b_r;

  always_comb begin
    y_b     = 40'((sq_a_r + QUAD_BIAS) >> 16);
    prod1_b = 46'(y_b[39:20]) * 46'(DIV25_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_b_r.valid <= 1'b0;
    end else if (en) begin
      it_b_r <= it_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_b_r <= big_a_r;
      lin_b_r <= lin_a_r;
      q1_b_r  <= prod1_b[DIV25_SHIFT+15:DIV25_SHIFT];
      yh_b_r  <= y_b[39:20];
      yl_b_r  <= y_b[19:0];
    end
  end

  // Stage C: remainder of the first digit joins the low half of the dividend.
  logic [19:0] q25_c;
  logic [19:0] rem_c;

  item_t              it_c_r;
  logic               big_c_r;
  logic signed [36:0] lin_c_r;
  logic [15:0]        q1_c_r;
  logic [24:0]        x2_c_r;

  always_comb begin
    q25_c = (20'(q1_b_r) << 4) + (20'(q1_b_r) << 3) + 20'(q1_b_r);
    rem_c = yh_b_r - q25_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_c_r.valid <= 1'b0;
    end else if (en) begin
      it_c_r <= it_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_c_r <= big_b_r;
      lin_c_r <= lin_b_r;
      q1_c_r  <= q1_b_r;
      x2_c_r  <= {rem_c[4:0], yl_b_r};
    end
  end

  // Stage D: second quotient digit.
  logic [50:0] prod2_d;

  item_t              it_d_r;
  logic               big_d_r;
  logic signed [36:0] lin_d_r;
  logic [15:0]        q1_d_r;
  logic [19:0]        q2_d_r;

  always_comb begin
    prod2_d = 51'(x2_c_r) * 51'(DIV25_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_d_r.valid <= 1'b0;
    end else if (en) begin
      it_d_r <= it_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_d_r <= big_c_r;
      lin_d_r <= lin_c_r;
      q1_d_r  <= q1_c_r;
      q2_d_r  <= prod2_d[DIV25_SHIFT+19:DIV25_SHIFT];
    end
  end

  // Stage E: sum, halve with floor, saturate. Load items keep their v.
  logic [35:0]        quad_e;
  logic signed [37:0] t_e;
  item_t              item_e;
  item_t              it_e_r;

  always_comb begin
    quad_e = big_d_r ? QUAD_CAP : {q1_d_r, q2_d_r};
    t_e    = $signed({2'b00, quad_e}) + 38'(lin_d_r);
    item_e = it_d_r;
    if (it_d_r.op == OP_TICK) begin
      item_e.v = sat32(40'(t_e >>> 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_e_r.valid <= 1'b0;
    end else if (en) begin
      it_e_r <= item_e;
    end
  end

  assign item_out = it_e_r;

  // Report whether any stage holds an item for the probed neuron.
  assign probe_hit = (it_a_r.valid && (it_a_r.neuron == probe_neuron)) ||
                     (it_b_r.valid && (it_b_r.neuron == probe_neuron)) ||
                     (it_c_r.valid && (it_c_r.neuron == probe_neuron)) ||
                     (it_d_r.valid && (it_d_r.neuron == probe_neuron)) ||
                     (it_e_r.valid && (it_e_r.neuron == probe_neuron));

endmodule

// ----- design/spiking_neuron_update.sv -----
// Top level of the Izhikevich neuron update pipeline with per-neuron v and u memory.
// Items flow through stages A, B, both half-steps, UA, UB, UC and the output register.
// Throughput: one item per cycle while items address different neurons and the output is
// not stalled; an item for a neuron still in flight waits until that neuron is written back.
// Reset clears all valid bits and loads the default configuration; the state memory is
// not cleared, so each neuron must be loaded before its first tick.
`timescale 1ns / 1ps

module spiking_neuron_update import snu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  snu_in_if.sink    in_if,
  snu_out_if.source out_if,
  snu_cfg_if.sink   cfg_if
);

  // Configuration registers.
  cfg_t cfg_r;

  assign cfg_if.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_exc     <= NUM_EXC_RST;
      cfg_r.threshold_v <= THRESHOLD_RST;
      cfg_r.reset_c     <= RESET_C_RST;
      cfg_r.recovery_b  <= RECOV_B_RST;
      cfg_r.a_exc       <= A_EXC_RST;
      cfg_r.a_inh       <= A_INH_RST;
      cfg_r.d_exc       <= D_EXC_RST;
      cfg_r.d_inh       <= D_INH_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_NUM_EXC:   cfg_r.num_exc     <= cfg_if.data[10:0];
        REG_THRESHOLD: cfg_r.threshold_v <= cfg_if.data;
        REG_RESET_C:   cfg_r.reset_c     <= cfg_if.data;
        REG_RECOV_B:   cfg_r.recovery_b  <= cfg_if.data[16:0];
        REG_A_EXC:     cfg_r.a_exc       <= cfg_if.data[16:0];
        REG_A_INH:     cfg_r.a_inh       <= cfg_if.data[16:0];
        REG_D_EXC:     cfg_r.d_exc       <= cfg_if.data;
        REG_D_INH:     cfg_r.d_inh       <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: everything moves when the output register is empty or being taken.
  logic  out_valid_r;
  logic  adv;
  logic  hazard;
  logic  in_fire;
  logic  wr_en;

  item_t sa_r;
  item_t sb_r;
  item_t h0_out;
  item_t h1_out;
  item_t ua_r;
  item_t ub_r;
  item_t uc_r;
  logic  h0_hit;
  logic  h1_hit;

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = rst_n && adv && !hazard;
  assign in_fire     = in_if.valid && in_if.ready;

  // An item may not read a neuron whose update has not been written back yet.
  assign hazard = (sa_r.valid && (sa_r.neuron == in_if.neuron)) ||
                  (sb_r.valid && (sb_r.neuron == in_if.neuron)) ||
                  h0_hit || h1_hit ||
                  (ua_r.valid && (ua_r.neuron == in_if.neuron)) ||
                  (ub_r.valid && (ub_r.neuron == in_if.neuron)) ||
                  (uc_r.valid && (uc_r.neuron == in_if.neuron));

  // State memory holds {u, v} per neuron; written as an item leaves the last stage.
  logic [63:0]        rd_data;
  logic signed [31:0] u_new;

  assign wr_en = rst_n && adv && uc_r.valid;

  snu_ram #(
    .WIDTH (64),
    .DEPTH (NEURONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (uc_r.neuron),
    .wdata ({u_new, uc_r.v}),
    .re    (adv),
    .raddr (in_if.neuron),
    .rdata (rd_data)
  );

  // Stage A: capture the item while the memory read is in progress.
  // A load item carries its initial values in the v and u slots.
  item_t item_in;

  always_comb begin
    item_in.valid  = in_fire;
    item_in.op     = op_t'(in_if.op);
    item_in.neuron = in_if.neuron;
    item_in.exc    = 1'b0;
    item_in.spiked = 1'b0;
    item_in.cur    = in_if.current;
    item_in.v      = in_if.init_v;
    item_in.u      = in_if.init_u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.valid <= 1'b0;
    end else if (adv) begin
      sa_r <= item_in;
    end
  end

  // Stage B: neuron class, spike test and spike reset of v and u.
  logic signed [31:0] v_mem;
  logic signed [31:0] u_mem;
  logic signed [31:0] d_sel;
  logic               exc_b;
  logic               spk_b;
  item_t              item_b;

  always_comb begin
    v_mem  = rd_data[31:0];
    u_mem  = rd_data[63:32];
    exc_b  = {1'b0, sa_r.neuron} < cfg_r.num_exc;
    d_sel  = exc_b ? cfg_r.d_exc : cfg_r.d_inh;
    spk_b  = v_mem >= cfg_r.threshold_v;
    item_b = sa_r;
    item_b.exc = exc_b;
    if (sa_r.op != OP_LOAD) begin
      item_b.spiked = spk_b;
      item_b.v      = spk_b ? cfg_r.reset_c : v_mem;
      item_b.u      = spk_b ? sat32(40'(u_mem) + 40'(d_sel)) : u_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else if (adv) begin
      sb_r <= item_b;
    end
  end

  // Two half-steps of the membrane integration.
  snu_half u_half0 (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .item_in      (sb_r),
    .item_out     (h0_out),
    .probe_neuron (in_if.neuron),
    .probe_hit    (h0_hit)
  );

  snu_half u_half1 (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .item_in      (h0_out),
    .item_out     (h1_out),
    .probe_neuron (in_if.neuron),
    .probe_hit    (h1_hit)
  );

  // Stage UA: b * v with the new v.
  logic signed [49:0] bv_prod;
  logic signed [49:0] ua_prod_r;

  assign bv_prod = 50'($signed({1'b0, cfg_r.recovery_b})) * 50'(h1_out.v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ua_r.valid <= 1'b0;
    end else if (adv) begin
      ua_r <= h1_out;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ua_prod_r <= bv_prod;
    end
  end

  // Stage UB: round b*v to Q16.16 and subtract u.
  logic signed [33:0] bv_ub;
  logic signed [34:0] diff_ub;
  logic signed [34:0] ub_diff_r;

  always_comb begin
    bv_ub   = 34'((ua_prod_r + 50'(RND_HALF)) >>> 16);
    diff_ub = 35'(bv_ub) - 35'(ua_r.u);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ub_r.valid <= 1'b0;
    end else if (adv) begin
      ub_r <= ua_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ub_diff_r <= diff_ub;
    end
  end

  // Stage UC: a * (b*v - u), with a chosen by neuron class.
  logic [16:0]        a_sel;
  logic signed [52:0] a_prod;
  logic signed [52:0] uc_prod_r;

  always_comb begin
    a_sel  = ub_r.exc ? cfg_r.a_exc : cfg_r.a_inh;
    a_prod = 53'($signed({1'b0, a_sel})) * 53'(ub_diff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uc_r.valid <= 1'b0;
    end else if (adv) begin
      uc_r <= ub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uc_prod_r <= a_prod;
    end
  end

  // Final u: round the product and accumulate with saturation. Load items keep u.
  logic signed [36:0] du;

  always_comb begin
    du    = 37'((uc_prod_r + 53'(RND_HALF)) >>> 16);
    u_new = (uc_r.op == OP_TICK) ? sat32(40'(uc_r.u) + 40'(du)) : uc_r.u;
  end

  // Output register.
  logic [NEURON_W-1:0] out_neuron_r;
  logic                out_spiked_r;
  logic signed [31:0]  out_v_r;
  logic signed [31:0]  out_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= uc_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_neuron_r <= uc_r.neuron;
      out_spiked_r <= uc_r.spiked;
      out_v_r      <= uc_r.v;
      out_u_r      <= u_new;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.neuron_out = out_neuron_r;
  assign out_if.spiked     = out_spiked_r;
  assign out_if.v_out      = out_v_r;
  assign out_if.u_out      = out_u_r;

  // Every write-back is matched by a result in the output register next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_if.valid)
    else $error("state written without a result");

  // Only tick items can report a spike.
  assert property (@(posedge clk) disable iff (!rst_n)
    sb_r.valid && sb_r.spiked |-> sb_r.op == OP_TICK)
    else $error("spike flagged on a load item");

  // A stalled pipeline keeps the item waiting for write-back.
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv && uc_r.valid |=> uc_r.valid && $stable(uc_r.neuron))
    else $error("item lost or changed during stall");

  // Reset empties the pipeline tail and the output register.
  assert property (@(posedge clk)
    !rst_n |=> !out_if.valid && !uc_r.valid)
    else $error("valid state survived reset");

endmodule
